/* hw/rtl/pcg32_pkg.sv */
// shared types and constants for the pcg32 random generator
package pcg32_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned FRAC_W = 27;

    localparam logic [WORD_W-1:0] PCG_MULT      = 64'h5851_f42d_4c95_7f2d;
    localparam logic [WORD_W-1:0] PCG_STATE_RST = 64'h853c_49e6_748f_ea9b;
    localparam logic [WORD_W-1:0] PCG_INC_RST   = 64'hda3e_39cb_94b9_5bdb;

    localparam logic [1:0] OP_SEED = 2'd0;
    localparam logic [1:0] OP_DRAW = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    // operand pairs for the shared 32x32 multiplier
    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_LO_HI = 2'd1;
    localparam logic [1:0] MUL_HI_LO = 2'd2;

    typedef struct packed {
        logic       take_seed;
        logic       load_words;
        logic       seed_sum;
        logic [1:0] mul_sel;
        logic       acc_init;
        logic       acc_add;
        logic       state_commit;
        logic       frac_capture;
        logic       out_write;
        logic       out_draw;
        logic       out_read;
    } pcg32_cmd_t;

endpackage

/* hw/rtl/pcg32_dpath.sv */
// pcg32 datapath: state, increment, shared multiplier, accumulator and result registers
module pcg32_dpath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pcg32_pkg::pcg32_cmd_t                 cmd,
    input  logic signed [pcg32_pkg::WORD_W-1:0]   seed_value,
    input  logic        [pcg32_pkg::WORD_W-1:0]   load_state_word,
    input  logic        [pcg32_pkg::WORD_W-1:0]   load_increment_word,
    output logic        [pcg32_pkg::FRAC_W-1:0]   random_fraction,
    output logic        [pcg32_pkg::HALF_W-1:0]   state_low,
    output logic        [pcg32_pkg::HALF_W-1:0]   increment_low
);
    import pcg32_pkg::*;

    logic [WORD_W-1:0] state_reg;
    logic [WORD_W-1:0] state_next;
    logic [WORD_W-1:0] inc_reg;
    logic [WORD_W-1:0] inc_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] prod_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [FRAC_W-1:0] frac_next;
    logic [FRAC_W-1:0] frac_out_reg;
    logic [FRAC_W-1:0] frac_out_next;
    logic [HALF_W-1:0] slo_reg;
    logic [HALF_W-1:0] slo_next;
    logic [HALF_W-1:0] ilo_reg;
    logic [HALF_W-1:0] ilo_next;

    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] seed_abs;
    logic [WORD_W-1:0] seed_fixed;
    logic [WORD_W-1:0] seed_inc;
    logic [WORD_W-1:0] prod_shifted;
    logic [WORD_W-1:0] xorshift;
    logic [HALF_W-1:0] mixed;
    logic [4:0]        rot;
    logic [HALF_W-1:0] rotated;

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_LO_HI:
            begin
                mul_a = state_reg[HALF_W-1:0];
                mul_b = PCG_MULT[WORD_W-1:HALF_W];
            end
            MUL_HI_LO:
            begin
                mul_a = state_reg[WORD_W-1:HALF_W];
                mul_b = PCG_MULT[HALF_W-1:0];
            end
            default:
            begin
                mul_a = state_reg[HALF_W-1:0];
                mul_b = PCG_MULT[HALF_W-1:0];
            end
        endcase
    end

    assign prod_next    = WORD_W'(mul_a) * WORD_W'(mul_b);
    assign prod_shifted = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    // absolute value of the seed, zero forced to one
    assign seed_abs   = seed_value[WORD_W-1] ? (~seed_value + WORD_W'(1)) : seed_value;
    assign seed_fixed = (seed_abs == '0) ? WORD_W'(1) : seed_abs;
    assign seed_inc   = {acc_reg[WORD_W-2:0], 1'b1};

    // xsh-rr output from the old state
    assign xorshift = (state_reg >> 18) ^ state_reg;
    assign mixed    = xorshift[HALF_W+26:27];
    assign rot      = state_reg[WORD_W-1:WORD_W-5];
    assign rotated  = (mixed >> rot) | (mixed << ((6'd32 - {1'b0, rot}) & 6'd31));

    always_comb
    begin
        state_next    = state_reg;
        inc_next      = inc_reg;
        acc_next      = acc_reg;
        frac_next     = frac_reg;
        frac_out_next = frac_out_reg;
        slo_next      = slo_reg;
        ilo_next      = ilo_reg;

        if (cmd.load_words)
        begin
            state_next = load_state_word;
            inc_next   = load_increment_word;
        end

        if (cmd.take_seed)
        begin
            acc_next = seed_fixed;
        end

        // first lcg step from a zero state leaves the increment, then the seed is added
        if (cmd.seed_sum)
        begin
            inc_next   = seed_inc;
            state_next = seed_inc + acc_reg;
        end

        if (cmd.acc_init)
        begin
            acc_next = prod_reg + inc_reg;
        end

        if (cmd.acc_add)
        begin
            acc_next = acc_reg + prod_shifted;
        end

        if (cmd.state_commit)
        begin
            state_next = acc_reg + prod_shifted;
        end

        if (cmd.frac_capture)
        begin
            frac_next = rotated[HALF_W-1:HALF_W-FRAC_W];
        end

        if (cmd.out_write)
        begin
            frac_out_next = cmd.out_draw ? frac_reg : '0;
            slo_next      = cmd.out_read ? state_reg[HALF_W-1:0] : '0;
            ilo_next      = cmd.out_read ? inc_reg[HALF_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PCG_STATE_RST;
            inc_reg   <= PCG_INC_RST;
        end
        else
        begin
            state_reg <= state_next;
            inc_reg   <= inc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        frac_reg     <= frac_next;
        frac_out_reg <= frac_out_next;
        slo_reg      <= slo_next;
        ilo_reg      <= ilo_next;
    end

    assign random_fraction = frac_out_reg;
    assign state_low       = slo_reg;
    assign increment_low   = ilo_reg;

endmodule

/* hw/rtl/pcg32_ctrl.sv */
// pcg32 controller: sequences seed, draw, read and load and owns both handshakes
module pcg32_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [1:0]             opcode,
    output logic                   result_valid,
    input  logic                   result_ready,
    output pcg32_pkg::pcg32_cmd_t  cmd
);
    import pcg32_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEED_SUM = 3'd1;
    localparam logic [2:0] S_MUL0     = 3'd2;
    localparam logic [2:0] S_MUL1     = 3'd3;
    localparam logic [2:0] S_MUL2     = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] op_reg;
    logic [1:0] op_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.mul_sel = MUL_LO_LO;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    op_next = opcode;
                    unique case (opcode)
                        OP_SEED:
                        begin
                            cmd.take_seed = 1'b1;
                            state_next    = S_SEED_SUM;
                        end
                        OP_DRAW:
                        begin
                            state_next = S_MUL0;
                        end
                        OP_READ:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            cmd.load_words = 1'b1;
                            state_next     = S_DONE;
                        end
                    endcase
                end
            end
            S_SEED_SUM:
            begin
                cmd.seed_sum = 1'b1;
                state_next   = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.mul_sel      = MUL_LO_LO;
                cmd.frac_capture = 1'b1;
                state_next       = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_sel  = MUL_LO_HI;
                cmd.acc_init = 1'b1;
                state_next   = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_sel = MUL_HI_LO;
                cmd.acc_add = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.state_commit = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_write = 1'b1;
                    cmd.out_draw  = (op_reg == OP_DRAW);
                    cmd.out_read  = (op_reg == OP_READ);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

/* hw/rtl/pcg32_random_generator.sv */
// top level of the pcg32 xsh-rr random generator
//
// input channel: item_valid / item_ready with opcode, seed_value, load_state_word and
// load_increment_word; opcode selects seed, draw, read or load
// output channel: result_valid / result_ready with random_fraction, state_low and
// increment_low; every input transfer yields exactly one result transfer
// one item is in work at a time; item_ready is high only while the controller is idle
// read and load go straight to the result; draw runs the lcg step first, and seed
// adds a seed-sum step before it; the controller is back in idle as the result is
// registered
// the 64-bit lcg step runs through one shared 32x32 multiplier in three passes
// plus a final add
// the result sits in an output register; while result_ready is low the block
// still takes the next item and holds its result until the register drains
// reset loads the standard pcg32 state and increment and empties the output
module pcg32_random_generator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic        [1:0]                    opcode,
    input  logic signed [pcg32_pkg::WORD_W-1:0]  seed_value,
    input  logic        [pcg32_pkg::WORD_W-1:0]  load_state_word,
    input  logic        [pcg32_pkg::WORD_W-1:0]  load_increment_word,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic        [pcg32_pkg::FRAC_W-1:0]  random_fraction,
    output logic        [pcg32_pkg::HALF_W-1:0]  state_low,
    output logic        [pcg32_pkg::HALF_W-1:0]  increment_low
);
    import pcg32_pkg::*;

    pcg32_cmd_t cmd;

    pcg32_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    pcg32_dpath u_dpath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .seed_value          (seed_value),
        .load_state_word     (load_state_word),
        .load_increment_word (load_increment_word),
        .random_fraction     (random_fraction),
        .state_low           (state_low),
        .increment_low       (increment_low)
    );

endmodule

/* tb/pcg32_random_generator_tb.sv */
// testbench for the pcg32 random generator: predicted results checked against every transfer
`timescale 1ns / 1ps

module pcg32_random_generator_tb;

    import pcg32_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 750;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        logic [1:0]        op;
        logic [FRAC_W-1:0] frac;
        logic [HALF_W-1:0] slo;
        logic [HALF_W-1:0] ilo;
    } pcg_result_t;

    class pcg32_scoreboard;
        logic [WORD_W-1:0] gen_state;
        logic [WORD_W-1:0] gen_inc;
        pcg_result_t       due_q[$];
        int                error_count;
        int                result_index;

        function new();
            gen_state    = PCG_STATE_RST;
            gen_inc      = PCG_INC_RST;
            error_count  = 0;
            result_index = 0;
        endfunction

        function logic [HALF_W-1:0] step_lcg();
            logic [WORD_W-1:0] prior;
            logic [WORD_W-1:0] folded;
            logic [HALF_W-1:0] mixed;
            logic [4:0]        rot;
            logic [4:0]        lrot;
            prior     = gen_state;
            gen_state = prior * PCG_MULT + gen_inc;
            folded    = ((prior >> 18) ^ prior) >> 27;
            mixed     = folded[HALF_W-1:0];
            rot       = prior[63:59];
            lrot      = 5'd0 - rot;
            return (mixed >> rot) | (mixed << lrot);
        endfunction

        function void note_item(logic [1:0] op, logic [WORD_W-1:0] seed,
                                logic [WORD_W-1:0] ls, logic [WORD_W-1:0] li);
            pcg_result_t       res;
            logic [WORD_W-1:0] mag;
            logic [HALF_W-1:0] drawn;
            res.op   = op;
            res.frac = '0;
            res.slo  = '0;
            res.ilo  = '0;
            case (op)
                OP_SEED:
                begin
                    mag = seed;
                    if (mag[WORD_W-1])
                        mag = ~mag + 64'd1;
                    if (mag == '0)
                        mag = 64'd1;
                    gen_state = '0;
                    gen_inc   = (mag << 1) | 64'd1;
                    void'(step_lcg());
                    gen_state = gen_state + mag;
                    void'(step_lcg());
                end
                OP_DRAW:
                begin
                    drawn    = step_lcg();
                    res.frac = drawn[HALF_W-1:5];
                end
                OP_READ:
                begin
                    res.slo = gen_state[HALF_W-1:0];
                    res.ilo = gen_inc[HALF_W-1:0];
                end
                default:
                begin
                    gen_state = ls;
                    gen_inc   = li;
                end
            endcase
            due_q.push_back(res);
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report_mismatch(string msg);
            error_count++;
            if (error_count <= PRINT_CAP)
                $display("[%0t] result %0d: %s", $time, result_index, msg);
        endtask

        task check_result(logic [FRAC_W-1:0] frac, logic [HALF_W-1:0] slo,
                          logic [HALF_W-1:0] ilo);
            pcg_result_t want;
            if (due_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer frac %h state %h inc %h",
                                          frac, slo, ilo));
            end
            else
            begin
                want = due_q.pop_front();
                if (frac !== want.frac)
                    report_mismatch($sformatf("op %0d random_fraction got %h want %h",
                                              want.op, frac, want.frac));
                if (slo !== want.slo)
                    report_mismatch($sformatf("op %0d state_low got %h want %h",
                                              want.op, slo, want.slo));
                if (ilo !== want.ilo)
                    report_mismatch($sformatf("op %0d increment_low got %h want %h",
                                              want.op, ilo, want.ilo));
            end
            result_index++;
        endtask
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     item_valid = 1'b0;
    logic                     item_ready;
    logic        [1:0]        opcode = OP_READ;
    logic signed [WORD_W-1:0] seed_value = '0;
    logic        [WORD_W-1:0] load_state_word = '0;
    logic        [WORD_W-1:0] load_increment_word = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic        [FRAC_W-1:0] random_fraction;
    logic        [HALF_W-1:0] state_low;
    logic        [HALF_W-1:0] increment_low;

    logic                     quiet_phase = 1'b0;
    int                       cycle_count = 0;
    pcg32_scoreboard          sb;

    pcg32_random_generator uut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_ready          (item_ready),
        .opcode              (opcode),
        .seed_value          (seed_value),
        .load_state_word     (load_state_word),
        .load_increment_word (load_increment_word),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .random_fraction     (random_fraction),
        .state_low           (state_low),
        .increment_low       (increment_low)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output side: check on transfer, then choose ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(random_fraction, state_low, increment_low);
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= quiet_phase || ($urandom_range(99) >= 28);
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] seed,
                             input logic [WORD_W-1:0] ls, input logic [WORD_W-1:0] li);
        int gap;
        gap = (!quiet_phase && $urandom_range(99) < 28) ? $urandom_range(3, 1) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid          <= 1'b1;
        opcode              <= op;
        seed_value          <= seed;
        load_state_word     <= ls;
        load_increment_word <= li;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(op, seed, ls, li);
    endtask

    task automatic send_op(input logic [1:0] op);
        send_item(op, rand64(), rand64(), rand64());
    endtask

    task automatic send_seed(input logic [WORD_W-1:0] seed);
        send_item(OP_SEED, seed, rand64(), rand64());
    endtask

    task automatic send_load(input logic [WORD_W-1:0] ls, input logic [WORD_W-1:0] li);
        send_item(OP_LOAD, rand64(), ls, li);
    endtask

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(7))
            0: return '0;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'($urandom_range(1000));
            3: return -64'($urandom_range(1000));
            4: return 64'h7fff_ffff_ffff_ffff;
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        int roll;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, seed corners, even and extreme loads
        send_op(OP_READ);
        send_op(OP_DRAW);
        send_op(OP_DRAW);
        send_op(OP_READ);
        send_seed(64'd0);
        send_op(OP_READ);
        send_op(OP_DRAW);
        send_seed(64'h8000_0000_0000_0000);
        send_op(OP_READ);
        send_op(OP_DRAW);
        send_seed(64'h7fff_ffff_ffff_ffff);
        send_op(OP_READ);
        send_seed(64'h8000_0000_0000_0001);
        send_op(OP_DRAW);
        send_seed(64'hffff_ffff_ffff_ffff);
        send_op(OP_READ);
        send_load(64'hffff_ffff_ffff_ffff, 64'd2);
        send_op(OP_READ);
        send_op(OP_DRAW);
        send_op(OP_DRAW);
        send_load(64'd0, 64'd0);
        send_op(OP_DRAW);
        send_op(OP_READ);
        send_load(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        send_op(OP_DRAW);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            quiet_phase <= (i >= 300 && i < 420);
            roll = $urandom_range(99);
            if (roll < 45)
                send_op(OP_DRAW);
            else if (roll < 70)
                send_op(OP_READ);
            else if (roll < 85)
                send_seed(pick_seed());
            else
                send_load(rand64(), rand64());
        end
        item_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
